[design/pcssd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcssd_pkg
// Shared types, constants and the segment decoder for the pulse counter
// with its three-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
package pcssd_pkg;

  localparam int unsigned CountWidth  = 16;
  localparam int unsigned FrameWidth  = 12;
  localparam int unsigned DigitWidth  = 4;
  localparam int unsigned SegWidth    = 8;
  localparam int unsigned SelectWidth = 3;

  localparam logic [FrameWidth-1:0] WindowReset = 12'd200;
  localparam logic [CountWidth-1:0] CountMax    = 16'hFFFF;
  localparam logic [DigitWidth-1:0] DigitMax    = 4'd9;

  // Select codes, one-hot per digit
  localparam logic [SelectWidth-1:0] SelOnes     = 3'b001;
  localparam logic [SelectWidth-1:0] SelTens     = 3'b010;
  localparam logic [SelectWidth-1:0] SelHundreds = 3'b100;

  typedef logic [DigitWidth-1:0] digit_t;

  typedef struct packed {
    digit_t hundreds;
    digit_t tens;
    digit_t ones;
  } digits_t;

  // Active-low segment code; anything outside 0..9 blanks the digit
  function automatic logic [SegWidth-1:0] seg_of(input digit_t d);
    logic [SegWidth-1:0] code;
    case (d)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hD8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = 8'hFF;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

[design/pcssd_counter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcssd_counter
// Falling-edge detector and edge counter. Keeps a binary count for the
// 16-bit wrap and a parallel decimal count of its low three digits.
// ----------------------------------------------------------------------------
module pcssd_counter
  import pcssd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    accept,
  input  wire logic    pin_level,
  input  wire logic    latch,
  output digits_t      live
);

  logic                  armed;
  logic [CountWidth-1:0] edge_count;
  digits_t               dec_count;
  digits_t               dec_inc;
  logic                  falling;

  assign falling = armed && !pin_level;

  // Decimal increment; the binary wrap to zero also zeroes the digits
  always_comb begin
    dec_inc = dec_count;
    if (edge_count == CountMax) begin
      dec_inc = '0;
    end else if (dec_count.ones != DigitMax) begin
      dec_inc.ones = dec_count.ones + 4'd1;
    end else begin
      dec_inc.ones = '0;
      if (dec_count.tens != DigitMax) begin
        dec_inc.tens = dec_count.tens + 4'd1;
      end else begin
        dec_inc.tens = '0;
        if (dec_count.hundreds != DigitMax) begin
          dec_inc.hundreds = dec_count.hundreds + 4'd1;
        end else begin
          dec_inc.hundreds = '0;
        end
      end
    end
  end

  // Count including this beat's edge, as seen by the window latch
  assign live = falling ? dec_inc : dec_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b0;
      edge_count <= '0;
      dec_count  <= '0;
    end else if (accept) begin
      armed <= pin_level;
      if (latch) begin
        edge_count <= '0;
        dec_count  <= '0;
      end else if (falling) begin
        edge_count <= edge_count + 16'd1;
        dec_count  <= dec_inc;
      end
    end
  end

endmodule
`default_nettype wire

[design/pulse_counter_seven_segment_display_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_counter_seven_segment_display_unit
// Counts falling edges of a sampled pin over a window of display frames and
// scans the latched three-digit count onto a multiplexed seven-segment display.
// ----------------------------------------------------------------------------
// Output: an accepted input beat's result is in the output register in the
//   cycle after the beat.
// Throughput: one beat per cycle; input stalls only while a result waits
//   untaken, set by the single output register.
// Reset: all counters, digits and outputs clear, window_limit returns to
//   200, and the first result after reset repeats the cleared outputs.
module pulse_counter_seven_segment_display_unit
  import pcssd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   pin_level,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SegWidth-1:0]         segments,
  output logic [SelectWidth-1:0]      digit_select,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [FrameWidth-1:0]  window_frames
);

  localparam logic [1:0] PosIdle     = 2'd0;
  localparam logic [1:0] PosOnes     = 2'd1;
  localparam logic [1:0] PosTens     = 2'd2;
  localparam logic [1:0] PosHundreds = 2'd3;

  logic                   accept;
  logic                   hit;
  logic [FrameWidth-1:0]  window_limit;
  logic [FrameWidth-1:0]  frame_count;
  logic [FrameWidth-1:0]  frame_count_next;
  logic [1:0]             scan_pos;
  logic [1:0]             scan_pos_next;
  digits_t                digits;
  digits_t                live;
  digits_t                shown;
  logic [SegWidth-1:0]    segments_next;
  logic [SelectWidth-1:0] select_next;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign hit   = frame_count >= window_limit;
  assign shown = hit ? live : digits;

  pcssd_counter u_counter (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pin_level (pin_level),
    .latch     (hit),
    .live      (live)
  );

  always_comb begin
    segments_next    = segments;
    select_next      = digit_select;
    frame_count_next = hit ? '0 : frame_count;
    scan_pos_next    = PosOnes;
    unique case (scan_pos)
      PosIdle: begin
        scan_pos_next = PosOnes;
      end
      PosOnes: begin
        segments_next    = seg_of(shown.ones);
        select_next      = SelOnes;
        frame_count_next = frame_count_next + 12'd1;
        scan_pos_next    = PosTens;
      end
      PosTens: begin
        segments_next = seg_of(shown.tens);
        select_next   = SelTens;
        scan_pos_next = PosHundreds;
      end
      PosHundreds: begin
        segments_next = seg_of(shown.hundreds);
        select_next   = SelHundreds;
        scan_pos_next = PosOnes;
      end
      default: begin
        scan_pos_next = PosOnes;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= WindowReset;
    end else if (cfg_valid && cfg_ready) begin
      window_limit <= window_frames;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= '0;
      scan_pos     <= PosIdle;
      digits       <= '0;
      segments     <= '0;
      digit_select <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        frame_count  <= frame_count_next;
        scan_pos     <= scan_pos_next;
        segments     <= segments_next;
        digit_select <= select_next;
        if (hit) begin
          digits <= live;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        // drop the beat once taken
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse counter and its multiplexed display.
// Feeds pin samples through the input channel, rewrites the window length
// between idle phases and checks every segment/select beat against directed
// rows or a local model of the edge counter, window latch and digit scan.
// ----------------------------------------------------------------------------
module tb_top;
  import pcssd_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainWait  = 4;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned HoldAfter  = 600;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned DirRows    = 22;

  localparam logic [SegWidth-1:0] SegBlank = 8'hFF;
  localparam logic [SegWidth-1:0] SegZero  = 8'hC0;
  localparam logic [SegWidth-1:0] SegCodes [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hD8, 8'h80, 8'h90
  };

  localparam logic [1:0] ScanIdle     = 2'd0;
  localparam logic [1:0] ScanOnes     = 2'd1;
  localparam logic [1:0] ScanTens     = 2'd2;
  localparam logic [1:0] ScanHundreds = 2'd3;

  typedef struct packed {
    logic [SegWidth-1:0]    seg;
    logic [SelectWidth-1:0] sel;
  } display_beat_t;

  typedef struct packed {
    logic                   pin;
    logic                   known;
    logic [SegWidth-1:0]    seg;
    logic [SelectWidth-1:0] sel;
  } pin_row_t;

  // Rows with known set carry the display beat expected right after reset
  localparam pin_row_t PinRows [DirRows] = '{
    '{1'b1, 1'b1, 8'h00,   3'b000},
    '{1'b0, 1'b1, SegZero, SelOnes},
    '{1'b1, 1'b1, SegZero, SelTens},
    '{1'b0, 1'b1, SegZero, SelHundreds},
    '{1'b1, 1'b1, SegZero, SelOnes},
    '{1'b1, 1'b0, 8'h00,   3'b000},
    '{1'b0, 1'b0, 8'h00,   3'b000},
    '{1'b0, 1'b0, 8'h00,   3'b000},
    '{1'b0, 1'b0, 8'h00,   3'b000},
    '{1'b1, 1'b0, 8'h00,   3'b000},
    '{1'b0, 1'b0, 8'h00,   3'b000},
    '{1'b1, 1'b0, 8'h00,   3'b000},
    '{1'b0, 1'b0, 8'h00,   3'b000},
    '{1'b1, 1'b0, 8'h00,   3'b000},
    '{1'b1, 1'b0, 8'h00,   3'b000},
    '{1'b1, 1'b0, 8'h00,   3'b000},
    '{1'b0, 1'b0, 8'h00,   3'b000},
    '{1'b0, 1'b0, 8'h00,   3'b000},
    '{1'b1, 1'b0, 8'h00,   3'b000},
    '{1'b0, 1'b0, 8'h00,   3'b000},
    '{1'b1, 1'b0, 8'h00,   3'b000},
    '{1'b0, 1'b0, 8'h00,   3'b000}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   pin_level = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SegWidth-1:0]    segments;
  logic [SelectWidth-1:0] digit_select;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [FrameWidth-1:0]  window_frames = WindowReset;

  // Typed expectation travelling with the pin beat
  logic                   drv_known = 1'b0;
  display_beat_t          drv_beat = '0;

  // Local model of the block
  logic                   m_armed;
  logic [CountWidth-1:0]  m_edges;
  logic [FrameWidth-1:0]  m_frames;
  logic [FrameWidth-1:0]  m_window;
  digit_t                 m_ones;
  digit_t                 m_tens;
  digit_t                 m_hund;
  logic [1:0]             m_scan;
  logic [SegWidth-1:0]    m_seg;
  logic [SelectWidth-1:0] m_sel;

  display_beat_t          display_q[$];
  int unsigned            mismatches = 0;
  int unsigned            results_seen = 0;
  int unsigned            cycles = 0;
  int unsigned            burst_left = 0;
  int unsigned            hold_left = 0;
  logic                   hold_done = 1'b0;
  int unsigned            ready_pct = 100;
  int unsigned            pct_timer = 0;

  pulse_counter_seven_segment_display_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pin_level    (pin_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .segments     (segments),
    .digit_select (digit_select),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_frames(window_frames)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [SegWidth-1:0] segment_code(input digit_t d);
    if (d > 4'd9) return SegBlank;
    return SegCodes[d];
  endfunction

  task automatic reset_display_model();
    m_armed  = 1'b0;
    m_edges  = '0;
    m_frames = '0;
    m_window = WindowReset;
    m_ones   = '0;
    m_tens   = '0;
    m_hund   = '0;
    m_scan   = ScanIdle;
    m_seg    = '0;
    m_sel    = '0;
  endtask

  // One tick: edge detect, window latch, then advance the digit scan
  task automatic advance_display(input logic pin, output display_beat_t beat);
    int unsigned cnt;
    if (pin) begin
      m_armed = 1'b1;
    end else if (m_armed) begin
      m_armed = 1'b0;
      m_edges = m_edges + 1'b1;
    end
    if (m_frames >= m_window) begin
      cnt      = m_edges;
      m_frames = '0;
      m_ones   = digit_t'(cnt % 10);
      m_tens   = digit_t'((cnt / 10) % 10);
      m_hund   = digit_t'((cnt / 100) % 10);
      m_edges  = '0;
    end
    case (m_scan)
      ScanOnes: begin
        m_seg    = segment_code(m_ones);
        m_sel    = SelOnes;
        m_frames = m_frames + 1'b1;
      end
      ScanTens: begin
        m_seg = segment_code(m_tens);
        m_sel = SelTens;
      end
      ScanHundreds: begin
        m_seg = segment_code(m_hund);
        m_sel = SelHundreds;
      end
      default: ;
    endcase
    m_scan   = (m_scan == ScanHundreds) ? ScanOnes : m_scan + 2'd1;
    beat.seg = m_seg;
    beat.sel = m_sel;
  endtask

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  // Scoreboard: pop before push so a result is never matched to its own beat
  always @(posedge clk) begin
    display_beat_t want;
    display_beat_t pred;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (display_q.size() == 0) begin
          note_mismatch("unexpected beat", 0, {segments, digit_select});
        end else begin
          want = display_q.pop_front();
          if (segments !== want.seg)
            note_mismatch("segments", want.seg, segments);
          if (digit_select !== want.sel)
            note_mismatch("digit_select", want.sel, digit_select);
        end
      end
      if (in_valid && in_ready) begin
        advance_display(pin_level, pred);
        display_q.push_back(drv_known ? drv_beat : pred);
      end
    end
  end

  // Receiver: shifting ready density, plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HoldAfter) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else begin
      if (pct_timer == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pct <= 100;
          1:       ready_pct <= 80;
          2:       ready_pct <= 40;
          default: ready_pct <= 10;
        endcase
        pct_timer <= $urandom_range(20, 120);
      end else begin
        pct_timer <= pct_timer - 1;
      end
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drive one pin beat, opening a fresh burst after a random gap when due
  task automatic send_pin(input logic pin, input logic known, input display_beat_t beat);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    pin_level <= pin;
    drv_known <= known;
    drv_beat  <= beat;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic set_window(input logic [FrameWidth-1:0] frames);
    wait_idle();
    cfg_valid     <= 1'b1;
    window_frames <= frames;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_window   = frames;
  endtask

  // Pin stream made of noise, clean toggling, random-length runs and steady levels
  task automatic stream_pins(input int unsigned count);
    int unsigned left;
    int unsigned chunk;
    int unsigned mode;
    int unsigned run;
    logic        lvl;
    left = count;
    run  = 0;
    lvl  = 1'b0;
    while (left > 0) begin
      mode  = $urandom_range(0, 9);
      chunk = $urandom_range(8, 40);
      while (chunk > 0 && left > 0) begin
        if (mode < 2) begin
          lvl = $urandom_range(0, 1);
        end else if (mode < 6) begin
          lvl = !lvl;
        end else if (mode < 9) begin
          if (run == 0) begin
            lvl = !lvl;
            run = $urandom_range(1, 4);
          end
          run--;
        end
        send_pin(lvl, 1'b0, '0);
        chunk--;
        left--;
      end
    end
  endtask

  initial begin
    reset_display_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirRows; i++)
      send_pin(PinRows[i].pin, PinRows[i].known, {PinRows[i].seg, PinRows[i].sel});

    set_window(12'd1);
    stream_pins(150);
    set_window(12'd4000);
    stream_pins(300);
    // window drops below the running frame count: latch on the next tick
    set_window(12'd5);
    stream_pins(100);
    set_window(WindowReset);
    stream_pins(650);
    set_window(12'hAAA);
    stream_pins(60);
    set_window(12'h555);
    stream_pins(60);
    for (int p = 0; p < 8; p++) begin
      set_window($urandom_range(1, 40));
      stream_pins(70);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
design/pcssd_pkg.sv
design/pcssd_counter.sv
design/pulse_counter_seven_segment_display_unit.sv
bench/tb_top.sv
